@@ src/pel_pkg.sv @@
package pel_pkg;

  localparam int PEL_DEPTH = 64;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_FIND_LANE = 2'd2,
    OP_FIND_TIME = 2'd3
  } pel_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } pel_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } pel_state_t;

  typedef struct packed {
    logic [7:0]  lane;
    logic [31:0] event_time;
    logic [7:0]  kind;
  } pel_entry_t;

  // shift command broadcast to every cell
  typedef struct packed {
    logic       ins;
    logic       rem;
    logic [6:0] pos_idx;
    pel_entry_t entry;
  } pel_cmd_t;

  typedef struct packed {
    logic        by_time;
    logic [7:0]  lane;
    logic [31:0] event_time;
  } pel_key_t;

  typedef struct packed {
    logic [6:0] found_position;
    logic [6:0] length;
    logic       is_empty;
    logic [1:0] status;
  } pel_res_t;

endpackage

@@ src/pel_if.sv @@
interface pel_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  lane;
  logic [31:0] event_time;
  logic [7:0]  event_kind;
  logic [6:0]  position;

  modport source (output valid, operation, lane, event_time, event_kind, position,
                  input ready);
  modport sink   (input valid, operation, lane, event_time, event_kind, position,
                  output ready);
endinterface

interface pel_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] found_position;
  logic [6:0] length;
  logic       is_empty;
  logic [1:0] status;

  modport source (output valid, found_position, length, is_empty, status, input ready);
  modport sink   (input valid, found_position, length, is_empty, status, output ready);
endinterface

@@ src/pel_cell.sv @@
module pel_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pel_pkg::pel_cmd_t   cmd,
  input  pel_pkg::pel_key_t   key,
  input  logic [CNT_W-1:0]    count,
  input  pel_pkg::pel_entry_t prev_entry,
  input  pel_pkg::pel_entry_t next_entry,
  input  logic                tok_in,
  output pel_pkg::pel_entry_t entry,
  output logic                pass,
  output logic                halt
);
  import pel_pkg::*;

  localparam int IW = (CNT_W > 7) ? CNT_W + 1 : 8;
  localparam logic [IW-1:0]    MY_IDX = IW'(IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

  pel_entry_t entry_r, entry_nxt;
  logic       tok_r;
  logic [IW-1:0] pidx;
  logic       occ, fit;

  assign pidx = IW'(cmd.pos_idx);
  assign occ  = MY_CNT < count;
  assign fit  = key.by_time ? (entry_r.event_time <= key.event_time)
                            : (entry_r.lane <= key.lane);
  assign pass  = tok_r && occ && fit;
  assign halt  = tok_r && !(occ && fit);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins) begin
      if (MY_IDX == pidx) entry_nxt = cmd.entry;
      else if (MY_IDX > pidx) entry_nxt = prev_entry;
    end else if (cmd.rem) begin
      if (MY_IDX >= pidx) entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // search token walks one cell per cycle while entries fit the key
  always_ff @(posedge clk) begin
    if (!rst_n) tok_r <= 1'b0;
    else        tok_r <= tok_in;
  end

endmodule

@@ src/pel_ctrl.sv @@
module pel_ctrl #(
  parameter int DEPTH = pel_pkg::PEL_DEPTH,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  pel_in_if.sink            in_ch,
  pel_out_if.source         out_ch,
  input  logic [DEPTH-1:0]  halt,
  output pel_pkg::pel_cmd_t cmd,
  output pel_pkg::pel_key_t key,
  output logic              start,
  output logic [CNT_W-1:0]  count
);
  import pel_pkg::*;

  localparam int W = (CNT_W > 7) ? CNT_W + 1 : 8;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  pel_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  pel_key_t         key_r, key_nxt;
  pel_res_t         res_r, res_nxt;
  pel_res_t         out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic       accept, slot_free, full, ins_ok, rem_ok, imm_op, scan_done, have_res;
  logic [W-1:0] pos_w, cnt_w;
  pel_res_t   imm_res, find_res, new_res;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign imm_op      = accept && !in_ch.operation[1];
  assign scan_done   = (state_r == S_SCAN) && ((|halt) || (scan_r == FULL_CNT));
  assign have_res    = imm_op || scan_done;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_ch.operation[1]) state_nxt = S_SCAN;
        else if (imm_op && !slot_free)    state_nxt = S_HOLD;
      end
      S_SCAN: begin
        if (scan_done) state_nxt = slot_free ? S_IDLE : S_HOLD;
      end
      S_HOLD: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pos_w  = W'(in_ch.position);
    cnt_w  = W'(cnt_r);
    full   = (cnt_r == FULL_CNT);
    ins_ok = !full && (in_ch.position != 7'd0) && (pos_w <= cnt_w + W'(1));
    rem_ok = (in_ch.position != 7'd0) && (pos_w <= cnt_w);

    cmd.ins         = accept && (in_ch.operation == OP_INSERT) && ins_ok;
    cmd.rem         = accept && (in_ch.operation == OP_REMOVE) && rem_ok;
    cmd.pos_idx     = in_ch.position - 7'd1;
    cmd.entry.lane  = in_ch.lane;
    cmd.entry.event_time = in_ch.event_time;
    cmd.entry.kind  = in_ch.event_kind;

    cnt_nxt = cnt_r;
    if (cmd.ins)      cnt_nxt = cnt_r + CNT_W'(1);
    else if (cmd.rem) cnt_nxt = cnt_r - CNT_W'(1);

    imm_res.found_position = 7'd1;
    imm_res.length         = 7'(cnt_nxt);
    imm_res.is_empty       = (cnt_nxt == '0);
    if (in_ch.operation == OP_INSERT)
      imm_res.status = full ? ST_FULL : (ins_ok ? ST_OK : ST_RANGE);
    else
      imm_res.status = rem_ok ? ST_OK : ST_RANGE;

    find_res.found_position = 7'(scan_r) + 7'd1;
    find_res.length         = 7'(cnt_r);
    find_res.is_empty       = (cnt_r == '0);
    find_res.status         = ST_OK;

    new_res = imm_op ? imm_res : find_res;

    start   = accept && in_ch.operation[1];
    key_nxt = key_r;
    if (start) begin
      key_nxt.by_time    = (in_ch.operation == OP_FIND_TIME);
      key_nxt.lane       = in_ch.lane;
      key_nxt.event_time = in_ch.event_time;
    end

    scan_nxt = scan_r;
    if (start)                                scan_nxt = '0;
    else if (state_r == S_SCAN && !scan_done) scan_nxt = scan_r + CNT_W'(1);

    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (have_res && slot_free) begin
      out_nxt       = new_res;
      out_valid_nxt = 1'b1;
    end else if (state_r == S_HOLD && slot_free) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (have_res && !slot_free) res_nxt = new_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    key_r  <= key_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign key   = key_r;
  assign count = cnt_r;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.found_position = out_r.found_position;
  assign out_ch.length         = out_r.length;
  assign out_ch.is_empty       = out_r.is_empty;
  assign out_ch.status         = out_r.status;

endmodule

@@ src/positional_event_list_top.sv @@
// Bounded ordered event list held in a row of DEPTH cells, one entry per cell.
// Insert and remove shift the row: an item is taken, the cells move, and the
// word is in the output register at the next edge if that register is free,
// so these run one per cycle while results are taken. A find sends a token
// down the row, one cell per cycle, comparing each entry against the key.
// With k the number of leading entries that fit the key (at most the list
// length), the token halts at the cell after them, or leaves a full row,
// and the word, with position k+1, is loaded into the output register when
// the scan ends if that register is free. No new word is taken during a find.
// A result waiting on the output side does not stop the next word being
// taken; one further result is held until the output register frees.
// Entries need no clearing after reset.
module positional_event_list_top #(
  parameter int DEPTH = pel_pkg::PEL_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  pel_in_if.sink    in_ch,
  pel_out_if.source out_ch
);
  import pel_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  pel_cmd_t         cmd;
  pel_key_t         key;
  logic             start;
  logic [CNT_W-1:0] count;
  logic [DEPTH-1:0] halt;
  logic [DEPTH-1:0] pass;
  pel_entry_t       ents [DEPTH];

  pel_ctrl #(.DEPTH(DEPTH), .CNT_W(CNT_W)) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .halt   (halt),
    .cmd    (cmd),
    .key    (key),
    .start  (start),
    .count  (count)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    pel_entry_t prev_e, next_e;
    logic       tok_in;

    if (i == 0) begin : g_first
      assign prev_e = cmd.entry;
      assign tok_in = start;
    end else begin : g_mid
      assign prev_e = ents[i-1];
      assign tok_in = pass[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_e = ents[i];
    end else begin : g_nlast
      assign next_e = ents[i+1];
    end

    pel_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .key        (key),
      .count      (count),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .tok_in     (tok_in),
      .entry      (ents[i]),
      .pass       (pass[i]),
      .halt       (halt[i])
    );
  end

endmodule

@@ src/pel_checker.sv @@
module pel_checker #(
  parameter int DEPTH = pel_pkg::PEL_DEPTH
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] found_position,
  input logic [6:0] length,
  input logic       is_empty,
  input logic [1:0] status
);
  import pel_pkg::*;

  localparam logic [6:0] DEPTH7 = 7'(DEPTH);
  localparam bit NO_WRAP = (DEPTH < 128);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(found_position)
      && $stable(length) && $stable(is_empty) && $stable(status))
    else $error("result word changed while stalled");

  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && NO_WRAP |-> (is_empty == (length == 7'd0)) && (length <= DEPTH7))
    else $error("empty flag or length inconsistent");

  a_err_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_OK) |-> found_position == 7'd1)
    else $error("failed operation reported a position");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_FULL) |-> length == DEPTH7)
    else $error("full status with list not full");

endmodule

bind positional_event_list_top pel_checker #(.DEPTH(DEPTH)) u_pel_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .found_position (out_ch.found_position),
  .length         (out_ch.length),
  .is_empty       (out_ch.is_empty),
  .status         (out_ch.status)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

// Mirror of the event list: applies each accepted word and queues the result it should give.
class event_list_board;
  pel_pkg::pel_entry_t cells[pel_pkg::PEL_DEPTH];
  int unsigned fill = 0;
  pel_pkg::pel_res_t pending[$];
  int unsigned fails = 0;

  // number of leading entries not above the key; the scan stops at the first miss
  function int unsigned leading_fits(bit by_time, logic [7:0] lane_key, logic [31:0] time_key);
    int unsigned i;
    i = 0;
    while (i < fill) begin
      if (by_time ? (cells[i].event_time > time_key) : (cells[i].lane > lane_key)) break;
      i++;
    end
    return i;
  endfunction

  function void note(pel_pkg::pel_op_t op, logic [7:0] lane, logic [31:0] event_time,
                     logic [7:0] kind, logic [6:0] position);
    pel_pkg::pel_res_t r;
    pel_pkg::pel_status_t st;
    int unsigned found;
    int k;
    found = 1;
    st = pel_pkg::ST_OK;
    case (op)
      pel_pkg::OP_INSERT: begin
        // a full list is flagged before the position is looked at
        if (fill >= pel_pkg::PEL_DEPTH) begin
          st = pel_pkg::ST_FULL;
        end else if (position < 1 || position > fill + 1) begin
          st = pel_pkg::ST_RANGE;
        end else begin
          for (k = int'(fill); k >= int'(position); k--) cells[k] = cells[k - 1];
          cells[position - 1].lane = lane;
          cells[position - 1].event_time = event_time;
          cells[position - 1].kind = kind;
          fill++;
        end
      end
      pel_pkg::OP_REMOVE: begin
        if (position < 1 || position > fill) begin
          st = pel_pkg::ST_RANGE;
        end else begin
          for (k = int'(position); k < int'(fill); k++) cells[k - 1] = cells[k];
          fill--;
        end
      end
      default: begin
        found = leading_fits(op == pel_pkg::OP_FIND_TIME, lane, event_time) + 1;
      end
    endcase
    r.found_position = 7'(found);
    r.length = 7'(fill);
    r.is_empty = (fill == 0);
    r.status = st;
    pending.push_back(r);
  endfunction

  function void check(logic [6:0] found_position, logic [6:0] length, logic is_empty,
                      logic [1:0] status);
    pel_pkg::pel_res_t want;
    if (pending.size() == 0) begin
      $error("result word with nothing expected: found_position %0d length %0d",
             found_position, length);
      fails++;
      return;
    end
    want = pending.pop_front();
    if (found_position !== want.found_position) begin
      $error("found_position: expected %0d, got %0d", want.found_position, found_position);
      fails++;
    end
    if (length !== want.length) begin
      $error("length: expected %0d, got %0d", want.length, length);
      fails++;
    end
    if (is_empty !== want.is_empty) begin
      $error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
      fails++;
    end
    if (status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, status);
      fails++;
    end
  endfunction
endclass

module testbench;
  import pel_pkg::*;

  localparam int IDLE_LIMIT   = 3000;
  localparam int TAIL_CYCLES  = 100;
  localparam int RANDOM_WORDS = 1700;

  logic clk;
  logic rst_n;
  bit   calm;
  bit   order_by_time;
  event_list_board sb;

  pel_in_if  in_ch();
  pel_out_if out_ch();

  positional_event_list_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // narrow ranges give plenty of ties for the finds
  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2, 3, 4, 5: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_lane();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2, 3, 4, 5: return 8'($urandom_range(0, 7));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_op(pel_op_t op, logic [7:0] lane, logic [31:0] event_time,
                         logic [7:0] kind, logic [6:0] position);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.operation  = op;
    in_ch.lane       = lane;
    in_ch.event_time = event_time;
    in_ch.event_kind = kind;
    in_ch.position   = position;
    in_ch.valid      = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // mode 0 fills, 1 drains, 2 mixes
  task automatic random_step(int unsigned mode);
    pel_op_t op;
    logic [7:0] lane;
    logic [31:0] event_time;
    logic [7:0] kind;
    logic [6:0] position;
    int unsigned r;
    int unsigned n;
    int unsigned j;
    n = sb.fill;
    r = $urandom_range(0, 99);
    lane = pick_lane();
    event_time = pick_time();
    kind = 8'($urandom);
    position = 7'($urandom);
    case (mode)
      0: op = (r < 75) ? OP_INSERT : (r < 92) ? OP_FIND_LANE : OP_REMOVE;
      1: op = (r < 65) ? OP_REMOVE : (r < 85) ? OP_FIND_LANE : OP_INSERT;
      default: op = (r < 35) ? OP_INSERT : (r < 65) ? OP_REMOVE : OP_FIND_LANE;
    endcase
    if (op == OP_FIND_LANE && $urandom_range(0, 1)) op = OP_FIND_TIME;
    r = $urandom_range(0, 9);
    case (op)
      OP_INSERT: begin
        // half the time keep the list in order so the finds reach deep
        if (r < 5) position = 7'(sb.leading_fits(order_by_time, lane, event_time) + 1);
        else if (r < 9) position = 7'($urandom_range(1, n + 1));
      end
      OP_REMOVE: begin
        if (r < 9) position = (n == 0) ? 7'd1 : 7'($urandom_range(1, n));
      end
      default: begin
        if (n != 0 && r < 5) begin
          j = $urandom_range(0, n - 1);
          lane = sb.cells[j].lane;
          event_time = sb.cells[j].event_time;
        end
      end
    endcase
    send_op(op, lane, event_time, kind, position);
  endtask

  // result side: random back-pressure
  initial begin
    int unsigned hold;
    out_ch.ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_ch.ready = 1'b1;
      end else if (hold != 0) begin
        out_ch.ready = 1'b0;
        hold--;
      end else begin
        out_ch.ready = 1'b1;
        hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check(out_ch.found_position, out_ch.length, out_ch.is_empty, out_ch.status);
      if (in_ch.valid && in_ch.ready)
        sb.note(pel_op_t'(in_ch.operation), in_ch.lane, in_ch.event_time, in_ch.event_kind,
                in_ch.position);
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("testbench failed");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned span;
    int unsigned mode;
    sb = new();
    calm = 1'b0;
    order_by_time = 1'b1;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_INSERT;
    in_ch.lane = '0;
    in_ch.event_time = '0;
    in_ch.event_kind = '0;
    in_ch.position = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // empty list: finds, removes and out-of-range inserts
    send_op(OP_FIND_LANE, 8'h00, 32'h0, 8'h00, 7'd1);
    send_op(OP_FIND_TIME, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 7'd1);
    send_op(OP_REMOVE, 8'h00, 32'h0, 8'h00, 7'd1);
    send_op(OP_REMOVE, 8'h00, 32'h0, 8'h00, 7'd0);
    send_op(OP_INSERT, 8'h12, 32'h1, 8'h34, 7'd0);
    send_op(OP_INSERT, 8'h12, 32'h1, 8'h34, 7'd2);
    send_op(OP_INSERT, 8'h12, 32'h1, 8'h34, 7'd127);
    // lanes end up 0, 7f, ff, 80: a lane find stops at the ff before reaching the 80
    send_op(OP_INSERT, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 7'd1);
    send_op(OP_INSERT, 8'h00, 32'h0, 8'h00, 7'd1);
    send_op(OP_INSERT, 8'h80, 32'h8000_0000, 8'h55, 7'd3);
    send_op(OP_INSERT, 8'h7F, 32'h7FFF_FFFF, 8'hAA, 7'd2);
    send_op(OP_FIND_LANE, 8'h00, 32'hFFFF_FFFF, 8'h00, 7'd1);
    send_op(OP_FIND_LANE, 8'hFF, 32'h0, 8'h00, 7'd1);
    send_op(OP_FIND_LANE, 8'h80, 32'h0, 8'h00, 7'd1);
    send_op(OP_FIND_TIME, 8'hFF, 32'h0, 8'h00, 7'd1);
    send_op(OP_FIND_TIME, 8'h00, 32'hFFFF_FFFF, 8'h00, 7'd1);
    send_op(OP_FIND_TIME, 8'h00, 32'h7FFF_FFFF, 8'h00, 7'd1);
    send_op(OP_REMOVE, 8'h00, 32'h0, 8'h00, 7'd4);
    send_op(OP_REMOVE, 8'h00, 32'h0, 8'h00, 7'd4);
    send_op(OP_REMOVE, 8'h00, 32'h0, 8'h00, 7'd1);
    send_op(OP_REMOVE, 8'h00, 32'h0, 8'h00, 7'd2);
    send_op(OP_REMOVE, 8'h00, 32'h0, 8'h00, 7'd1);
    send_op(OP_REMOVE, 8'h00, 32'h0, 8'h00, 7'd1);

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      mode = $urandom_range(0, 9);
      mode = (mode < 4) ? 0 : (mode < 7) ? 1 : 2;
      span = (mode == 0) ? $urandom_range(60, 200) : $urandom_range(30, 120);
      calm = ($urandom_range(0, 4) == 0);
      order_by_time = $urandom_range(0, 1);
      repeat (span) begin
        random_step(mode);
        sent++;
      end
    end
    calm = 1'b0;
    in_ch.valid = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fails == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end
endmodule
